FILE: rtl/gpc_pkg.sv
package gpc_pkg;

  localparam int MAX_COORD = 127;
  localparam int SIDE      = MAX_COORD + 1;
  localparam int COORD_W   = $clog2(SIDE);
  localparam int COUNT_W   = 64;
  localparam int CFG_IDX_W = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COUNT_W-1:0] count_t;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  // opcodes
  localparam logic OP_LOAD_EDGE = 1'b0;
  localparam logic OP_COUNT     = 1'b1;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic   clr_en;    // clear blocked-edge row x
    logic   load_en;   // store one blocked edge from the input fields
    logic   row_rd;    // fetch blocked rows for column x
    logic   calc;      // compute cell (x, y)
    logic   run_init;  // start of a count run
    coord_t x;
    coord_t y;
  } gpc_cmd_t;

endpackage

FILE: rtl/grid_path_count_blocked_edges_core.sv
// an edge load (opcode 0) is taken with busy low and leaves busy low, so loads stream one per cycle
// a count (opcode 1) walks the grid column by column and then strobes done;
//   each column is one row fetch followed by h+1 cell updates
// a new count is taken only after the walk and a clearing pass of the blocked maps, both with busy high
// reset: synchronous, active high; a clearing pass of the blocked maps follows
//   with busy high; the receiver cannot stall, done is a one-cycle strobe
module grid_path_count_blocked_edges_core (
  input  logic                            clk,
  input  logic                            rst,
  // command side
  input  logic                            start,
  output logic                            busy,
  input  logic                            opcode,
  input  logic [6:0]                      first_x,
  input  logic [6:0]                      first_y,
  input  logic [6:0]                      second_x,
  input  logic [6:0]                      second_y,
  // result side
  output logic                            done,
  output logic [63:0]                     path_count,
  output logic                            overflowed,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [6:0]                      cfg_data
);

  // command bundle from sequencer to datapath
  gpc_pkg::gpc_cmd_t cmd;

  // sequencer: clear pass, edge loads, column walk, result strobe
  gpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd)
  );

  // datapath: blocked-edge maps, column store and the saturating adder
  gpc_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .first_x    (first_x),
    .first_y    (first_y),
    .second_x   (second_x),
    .second_y   (second_y),
    .path_count (path_count),
    .overflowed (overflowed)
  );

endmodule

FILE: rtl/gpc_ctrl.sv
module gpc_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            opcode,
  input  logic                            cfg_valid,
  input  logic [gpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  gpc_pkg::coord_t                 cfg_data,
  output logic                            cfg_ready,
  output logic                            busy,
  output logic                            done,
  output gpc_pkg::gpc_cmd_t               cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_ROWRD = 5'b00100,
    ST_CALC  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t          state, state_next;
  gpc_pkg::coord_t x, x_next;
  gpc_pkg::coord_t y, y_next;
  gpc_pkg::coord_t grid_width;
  gpc_pkg::coord_t grid_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      x           <= '0;
      y           <= '0;
      grid_width  <= '0;
      grid_height <= '0;
    end else begin
      state <= state_next;
      x     <= x_next;
      y     <= y_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          gpc_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
          gpc_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    state_next   = state;
    x_next       = x;
    y_next       = y;
    cmd          = '0;
    cmd.x        = x;
    cmd.y        = y;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (x == gpc_pkg::coord_t'(gpc_pkg::MAX_COORD)) begin
          x_next     = '0;
          state_next = ST_IDLE;
        end else begin
          x_next = x + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (opcode == gpc_pkg::OP_COUNT) begin
            cmd.run_init = 1'b1;
            x_next       = '0;
            y_next       = '0;
            state_next   = ST_ROWRD;
          end else begin
            cmd.load_en = 1'b1;
          end
        end
      end
      ST_ROWRD: begin
        cmd.row_rd = 1'b1;
        y_next     = '0;
        state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        if (y == grid_height) begin
          y_next = '0;
          if (x == grid_width) begin
            state_next = ST_DONE;
          end else begin
            x_next     = x + 1'b1;
            state_next = ST_ROWRD;
          end
        end else begin
          y_next = y + 1'b1;
        end
      end
      ST_DONE: begin
        x_next     = '0;
        state_next = ST_CLEAR;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign done      = (state == ST_DONE);

endmodule

FILE: rtl/gpc_dp.sv
module gpc_dp (
  input  logic              clk,
  input  gpc_pkg::gpc_cmd_t cmd,
  input  gpc_pkg::coord_t   first_x,
  input  gpc_pkg::coord_t   first_y,
  input  gpc_pkg::coord_t   second_x,
  input  gpc_pkg::coord_t   second_y,
  output gpc_pkg::count_t   path_count,
  output logic              overflowed
);

  // blocked maps, one row of bits per x coordinate
  logic [gpc_pkg::SIDE-1:0] blk_x_mem [gpc_pkg::SIDE];
  logic [gpc_pkg::SIDE-1:0] blk_y_mem [gpc_pkg::SIDE];
  logic [gpc_pkg::SIDE-1:0] blk_x_row;
  logic [gpc_pkg::SIDE-1:0] blk_y_row;

  // counts of the current column, one per row
  gpc_pkg::count_t col_mem [gpc_pkg::SIDE];
  gpc_pkg::count_t col_rd;
  gpc_pkg::count_t below;
  logic            sat;

  gpc_pkg::coord_t lo_x, lo_y, hi_x, hi_y;
  logic            swap, is_x_edge, is_y_edge;
  gpc_pkg::coord_t x_prev, y_prev, col_rd_addr;
  gpc_pkg::count_t from_left, from_below;
  logic [gpc_pkg::COUNT_W:0] sum;
  gpc_pkg::count_t cell_val;

  // canonical endpoint order, then unit adjacency
  always_comb begin
    swap = (first_x > second_x) || ((first_x == second_x) && (first_y > second_y));
    lo_x = swap ? second_x : first_x;
    lo_y = swap ? second_y : first_y;
    hi_x = swap ? first_x  : second_x;
    hi_y = swap ? first_y  : second_y;
    is_x_edge = (lo_y == hi_y) && ({1'b0, hi_x} == ({1'b0, lo_x} + 8'd1));
    is_y_edge = (lo_x == hi_x) && ({1'b0, hi_y} == ({1'b0, lo_y} + 8'd1));
  end

  assign x_prev      = cmd.x - 1'b1;
  assign y_prev      = cmd.y - 1'b1;
  assign col_rd_addr = cmd.row_rd ? '0 : cmd.y + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      blk_x_mem[cmd.x] <= '0;
    end else if (cmd.load_en && is_x_edge) begin
      blk_x_mem[lo_x][lo_y] <= 1'b1;
    end
    if (cmd.row_rd) begin
      blk_x_row <= blk_x_mem[x_prev];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      blk_y_mem[cmd.x] <= '0;
    end else if (cmd.load_en && is_y_edge) begin
      blk_y_mem[lo_x][lo_y] <= 1'b1;
    end
    if (cmd.row_rd) begin
      blk_y_row <= blk_y_mem[cmd.x];
    end
  end

  // saturating cell update
  always_comb begin
    if (cmd.x == '0) begin
      from_left = (cmd.y == '0) ? gpc_pkg::count_t'(1) : '0;
    end else begin
      from_left = blk_x_row[cmd.y] ? '0 : col_rd;
    end
    if (cmd.y == '0) begin
      from_below = '0;
    end else begin
      from_below = blk_y_row[y_prev] ? '0 : below;
    end
    sum      = {1'b0, from_left} + {1'b0, from_below};
    cell_val = sum[gpc_pkg::COUNT_W] ? '1 : sum[gpc_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      col_mem[cmd.y] <= cell_val;
    end
    col_rd <= col_mem[col_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      below <= cell_val;
    end
    if (cmd.run_init) begin
      sat <= 1'b0;
    end else if (cmd.calc && sum[gpc_pkg::COUNT_W]) begin
      sat <= 1'b1;
    end
  end

  assign path_count = below;
  assign overflowed = sat;

endmodule

FILE: rtl/gpc_checker.sv
module gpc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic opcode,
  input logic done
);

  // after reset the clearing pass keeps the block busy
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  // a result only appears while a count is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // one result per count, then the maps are cleared
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> (!done && busy))
    else $error("result repeated or clear skipped");

  // an edge load never blocks the next command
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !opcode) |=> !busy)
    else $error("edge load raised busy");

  // a count start always goes busy
  a_count_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode) |=> busy)
    else $error("count start did not raise busy");

endmodule

bind grid_path_count_blocked_edges_core gpc_checker u_gpc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .opcode (opcode),
  .done   (done)
);

FILE: tb/tb_top.sv
module tb_top;

  // watchdog on the whole run, set above the slowest legal run
  localparam int unsigned     CYCLE_LIMIT  = 2_000_000;
  // a count ends with a clearing pass of the blocked maps, so wait past it
  localparam int unsigned     CLEAR_WAIT   = 140;
  localparam int unsigned     SETTLE_WAIT  = 200;
  localparam int              OPENING_ROWS = 26;
  localparam int              PHASES       = 11;
  localparam gpc_pkg::count_t ALL_ONES     = '1;

  typedef enum logic {ROW_GRID, ROW_ITEM} row_kind_t;

  typedef struct packed {
    gpc_pkg::count_t path_count;
    logic            overflowed;
  } tally_t;

  // one line of stimulus; for ROW_GRID rows ax/ay carry the corner width/height
  typedef struct packed {
    row_kind_t       kind;
    logic            op;
    gpc_pkg::coord_t ax;
    gpc_pkg::coord_t ay;
    gpc_pkg::coord_t bx;
    gpc_pkg::coord_t by;
    logic            typed;       // want_* holds a hand-written answer
    gpc_pkg::count_t want_count;
    logic            want_ov;
  } plan_row_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  // block ports, all known from time zero
  logic                          start      = 1'b0;
  logic                          busy;
  logic                          opcode     = gpc_pkg::OP_LOAD_EDGE;
  logic [6:0]                    first_x    = '0;
  logic [6:0]                    first_y    = '0;
  logic [6:0]                    second_x   = '0;
  logic [6:0]                    second_y   = '0;
  logic                          done;
  logic [63:0]                   path_count;
  logic                          overflowed;
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [gpc_pkg::CFG_IDX_W-1:0] cfg_index  = gpc_pkg::REG_GRID_WIDTH;
  logic [6:0]                    cfg_data   = '0;

  grid_path_count_blocked_edges_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .first_x    (first_x),
    .first_y    (first_y),
    .second_x   (second_x),
    .second_y   (second_y),
    .done       (done),
    .path_count (path_count),
    .overflowed (overflowed),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow of the block's state: corner registers and the two blocked-edge maps
  int unsigned grid_w = 0;
  int unsigned grid_h = 0;
  bit blocked_right [0:gpc_pkg::MAX_COORD][0:gpc_pkg::MAX_COORD];  // edge (x,y)-(x+1,y)
  bit blocked_up    [0:gpc_pkg::MAX_COORD][0:gpc_pkg::MAX_COORD];  // edge (x,y)-(x,y+1)

  tally_t      pending_tallies [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;

  // directed opening: corners at reset, a 1x1 grid with every kind of load,
  // then the extreme corners
  plan_row_t opening_plan [OPENING_ROWS] = '{
    // reset corner (0,0): the single empty path
    '{ROW_ITEM, gpc_pkg::OP_COUNT,     7'd0,   7'd0,   7'd0,   7'd0,   1'b1, 64'd1,    1'b0},
    '{ROW_GRID, gpc_pkg::OP_LOAD_EDGE, 7'd1,   7'd1,   7'd0,   7'd0,   1'b0, 64'd0,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_COUNT,     7'd0,   7'd0,   7'd0,   7'd0,   1'b1, 64'd2,    1'b0},
    // bottom edge blocked leaves up-then-right only
    '{ROW_ITEM, gpc_pkg::OP_LOAD_EDGE, 7'd0,   7'd0,   7'd1,   7'd0,   1'b0, 64'd0,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_COUNT,     7'd0,   7'd0,   7'd0,   7'd0,   1'b1, 64'd1,    1'b0},
    // maps were cleared by the last run
    '{ROW_ITEM, gpc_pkg::OP_COUNT,     7'd0,   7'd0,   7'd0,   7'd0,   1'b1, 64'd2,    1'b0},
    // both vertical edges, endpoints given high first
    '{ROW_ITEM, gpc_pkg::OP_LOAD_EDGE, 7'd1,   7'd1,   7'd1,   7'd0,   1'b0, 64'd0,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_LOAD_EDGE, 7'd0,   7'd1,   7'd0,   7'd0,   1'b0, 64'd0,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_COUNT,     7'd0,   7'd0,   7'd0,   7'd0,   1'b1, 64'd0,    1'b0},
    // ignored loads: equal endpoints, diagonal, two apart
    '{ROW_ITEM, gpc_pkg::OP_LOAD_EDGE, 7'd5,   7'd5,   7'd5,   7'd5,   1'b0, 64'd0,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_LOAD_EDGE, 7'd0,   7'd0,   7'd1,   7'd1,   1'b0, 64'd0,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_LOAD_EDGE, 7'd0,   7'd0,   7'd2,   7'd0,   1'b0, 64'd0,    1'b0},
    // top edge, then the same edge again in the other order
    '{ROW_ITEM, gpc_pkg::OP_LOAD_EDGE, 7'd0,   7'd1,   7'd1,   7'd1,   1'b0, 64'd0,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_LOAD_EDGE, 7'd1,   7'd1,   7'd0,   7'd1,   1'b0, 64'd0,    1'b0},
    // edges at the far corner of the coordinate space, outside the grid
    '{ROW_ITEM, gpc_pkg::OP_LOAD_EDGE, 7'd127, 7'd127, 7'd126, 7'd127, 1'b0, 64'd0,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_LOAD_EDGE, 7'd127, 7'd126, 7'd127, 7'd127, 1'b0, 64'd0,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_COUNT,     7'd0,   7'd0,   7'd0,   7'd0,   1'b0, 64'd0,    1'b0},
    // largest square saturates
    '{ROW_GRID, gpc_pkg::OP_LOAD_EDGE, 7'd127, 7'd127, 7'd0,   7'd0,   1'b0, 64'd0,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_COUNT,     7'd0,   7'd0,   7'd0,   7'd0,   1'b1, ALL_ONES, 1'b1},
    // single row, last edge cut
    '{ROW_GRID, gpc_pkg::OP_LOAD_EDGE, 7'd127, 7'd0,   7'd0,   7'd0,   1'b0, 64'd0,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_LOAD_EDGE, 7'd127, 7'd0,   7'd126, 7'd0,   1'b0, 64'd0,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_COUNT,     7'd0,   7'd0,   7'd0,   7'd0,   1'b1, 64'd0,    1'b0},
    // single column
    '{ROW_GRID, gpc_pkg::OP_LOAD_EDGE, 7'd0,   7'd127, 7'd0,   7'd0,   1'b0, 64'd0,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_COUNT,     7'd0,   7'd0,   7'd0,   7'd0,   1'b1, 64'd1,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_LOAD_EDGE, 7'd0,   7'd127, 7'd0,   7'd126, 1'b0, 64'd0,    1'b0},
    '{ROW_ITEM, gpc_pkg::OP_COUNT,     7'd0,   7'd0,   7'd0,   7'd0,   1'b0, 64'd0,    1'b0}
  };

  // random phases: mostly small grids, a few near the 64-bit limit, one full size
  int unsigned phase_w [PHASES] = '{3, 0, 6, 10, 33, 34, 20, 127, 0,   127, 5};
  int unsigned phase_h [PHASES] = '{3, 5, 0, 7,  33, 34, 60, 0,   127, 127, 9};
  int unsigned phase_n [PHASES] = '{250, 80, 80, 250, 120, 120, 100, 60, 60, 30, 200};

  // mark one blocked edge; anything that is not a unit step is dropped
  function automatic void record_blocked_edge(int unsigned ax, int unsigned ay,
                                              int unsigned bx, int unsigned by);
    int unsigned t;
    if (ax > bx || (ax == bx && ay > by)) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    if (ay == by && bx == ax + 1)
      blocked_right[ax][ay] = 1'b1;
    else if (ax == bx && by == ay + 1)
      blocked_up[ax][ay] = 1'b1;
  endfunction

  // column-by-column path count with saturating sums, then forget all edges
  function automatic tally_t count_paths();
    gpc_pkg::count_t           column [0:gpc_pkg::MAX_COORD];
    gpc_pkg::count_t           from_left;
    gpc_pkg::count_t           from_below;
    logic [gpc_pkg::COUNT_W:0] sum;
    tally_t                    t;
    t.overflowed = 1'b0;
    for (int x = 0; x <= grid_w; x++) begin
      for (int y = 0; y <= grid_h; y++) begin
        if (x == 0)
          from_left = (y == 0) ? gpc_pkg::count_t'(1) : '0;
        else
          from_left = blocked_right[x-1][y] ? '0 : column[y];
        if (y == 0)
          from_below = '0;
        else
          from_below = blocked_up[x][y-1] ? '0 : column[y-1];
        sum = {1'b0, from_left} + {1'b0, from_below};
        if (sum[gpc_pkg::COUNT_W]) begin
          column[y]    = ALL_ONES;
          t.overflowed = 1'b1;
        end else begin
          column[y] = sum[gpc_pkg::COUNT_W-1:0];
        end
      end
    end
    t.path_count = column[grid_h];
    foreach (blocked_right[i, j]) begin
      blocked_right[i][j] = 1'b0;
      blocked_up[i][j]    = 1'b0;
    end
    return t;
  endfunction

  // set a new corner once the block has drained; both registers per call
  task automatic set_grid(input int unsigned w, input int unsigned h);
    start <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    // last result is out, but the map clearing pass still runs
    repeat (CLEAR_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= gpc_pkg::REG_GRID_WIDTH;
    cfg_data  <= 7'(w);
    do @(posedge clk); while (!cfg_ready);
    grid_w = w;
    // valid stays high into the second transfer
    cfg_index <= gpc_pkg::REG_GRID_HEIGHT;
    cfg_data  <= 7'(h);
    do @(posedge clk); while (!cfg_ready);
    grid_h = h;
    cfg_valid <= 1'b0;
  endtask

  // one command transfer; start is left high so the next item can follow directly
  task automatic issue(input plan_row_t r);
    tally_t tally;
    if (burst_left == 0) begin
      // gap between bursts, never empty, so start really drops
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start    <= 1'b1;
    opcode   <= r.op;
    first_x  <= r.ax;
    first_y  <= r.ay;
    second_x <= r.bx;
    second_y <= r.by;
    do @(posedge clk); while (busy);
    if (r.op == gpc_pkg::OP_LOAD_EDGE) begin
      record_blocked_edge(r.ax, r.ay, r.bx, r.by);
    end else begin
      // always run the predictor so its maps are cleared like the block's
      tally = count_paths();
      if (r.typed) begin
        tally.path_count = r.want_count;
        tally.overflowed = r.want_ov;
      end
      pending_tallies = {pending_tallies, tally};
    end
  endtask

  // result side: done is a one-cycle strobe, compare against the oldest prediction
  always @(posedge clk) begin
    tally_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (pending_tallies.size() == 0) begin
        $error("path_count: no result expected, got %0d", path_count);
        mismatch_count++;
      end else begin
        want = pending_tallies.pop_front();
        if (path_count !== want.path_count) begin
          $error("path_count: expected %0d, got %0d", want.path_count, path_count);
          mismatch_count++;
        end
        if (overflowed !== want.overflowed) begin
          $error("overflowed: expected %0d, got %0d", want.overflowed, overflowed);
          mismatch_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus
  initial begin
    plan_row_t   r;
    int unsigned loads_left;
    int unsigned pick;
    int unsigned lx;
    int unsigned ly;
    bit          horiz;
    bit          near_grid;

    foreach (blocked_right[i, j]) begin
      blocked_right[i][j] = 1'b0;
      blocked_up[i][j]    = 1'b0;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (opening_plan[k]) begin
      if (opening_plan[k].kind == ROW_GRID)
        set_grid(opening_plan[k].ax, opening_plan[k].ay);
      else
        issue(opening_plan[k]);
    end

    // random phases, each on its own corner setting
    for (int p = 0; p < PHASES; p++) begin
      set_grid(phase_w[p], phase_h[p]);
      loads_left = $urandom_range(2, 16);
      for (int n = 0; n < phase_n[p]; n++) begin
        r      = '0;
        r.kind = ROW_ITEM;
        if (loads_left == 0) begin
          r.op       = gpc_pkg::OP_COUNT;
          loads_left = $urandom_range(2, 16);
        end else begin
          r.op = gpc_pkg::OP_LOAD_EDGE;
          loads_left--;
          pick = $urandom_range(0, 99);
          if (pick < 8) begin
            // degenerate edge, both endpoints the same
            r.ax = 7'($urandom);
            r.ay = 7'($urandom);
            r.bx = r.ax;
            r.by = r.ay;
          end else if (pick < 16) begin
            // raw noise, exercises every coordinate bit
            r.ax = 7'($urandom);
            r.ay = 7'($urandom);
            r.bx = 7'($urandom);
            r.by = 7'($urandom);
          end else begin
            // unit edge: mostly inside the grid, else anywhere in the space
            near_grid = (pick < 80) && (grid_w != 0 || grid_h != 0);
            if (near_grid) begin
              if (grid_h == 0)
                horiz = 1'b1;
              else if (grid_w == 0)
                horiz = 1'b0;
              else
                horiz = 1'($urandom_range(0, 1));
              lx = horiz ? $urandom_range(0, grid_w - 1) : $urandom_range(0, grid_w);
              ly = horiz ? $urandom_range(0, grid_h) : $urandom_range(0, grid_h - 1);
            end else begin
              horiz = 1'($urandom_range(0, 1));
              lx = horiz ? $urandom_range(0, gpc_pkg::MAX_COORD - 1)
                         : $urandom_range(0, gpc_pkg::MAX_COORD);
              ly = horiz ? $urandom_range(0, gpc_pkg::MAX_COORD)
                         : $urandom_range(0, gpc_pkg::MAX_COORD - 1);
            end
            r.ax = 7'(lx);
            r.ay = 7'(ly);
            r.bx = 7'(lx + horiz);
            r.by = 7'(ly + !horiz);
            // endpoint order does not matter to the block
            if ($urandom_range(0, 1))
              {r.ax, r.ay, r.bx, r.by} = {r.bx, r.by, r.ax, r.ay};
          end
        end
        issue(r);
      end
    end

    // drain, then give the clearing pass time to show any stray strobe
    start <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_tallies.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
